FILE: sv/ala_pkg.sv
// Shared types and constants for the affine local alignment block.
package ala_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_ALIGN       = 2'd2,
        OP_CLEAR       = 2'd3
    } opcode_t;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP_OPEN = 2'd2;
    localparam logic [1:0] REG_GAP_EXT  = 2'd3;

    localparam int SCORE_W = 16;

endpackage

FILE: sv/ala_ram.sv
// Generic simple dual-port RAM with registered read.
module ala_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/affine_local_alignment.sv
// Affine-gap local alignment: sequence stores, matrix fill and traceback.
// Loads and clears never raise busy; an align keeps busy high through the fill
// (matrix read, then compute and write per cell) and the traceback (current-cell read,
// diagonal read and compare per step); the single matrix read port sets this pace.
// The result beat is strobed in the first cycle with busy low (next cycle for an empty
// align); results never stall. Reset sets scores to 1/-1/-2/-1 and both lengths to zero.
module affine_local_alignment #(
    parameter int MAX_FIRST_LEN  = 128,
    parameter int MAX_SECOND_LEN = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  symbol,
    output logic        done,
    output logic        status,
    output logic [13:0] best_score,
    output logic [7:0]  first_start,
    output logic [7:0]  first_end,
    output logic [7:0]  second_start,
    output logic [7:0]  second_end,
    output logic [8:0]  path_length,
    output logic [7:0]  equal_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW     = ala_pkg::SCORE_W;
    localparam int IW     = $clog2(MAX_FIRST_LEN + 1);
    localparam int JW     = $clog2(MAX_SECOND_LEN + 1);
    localparam int A1W    = (MAX_FIRST_LEN > 1) ? $clog2(MAX_FIRST_LEN) : 1;
    localparam int A2W    = (MAX_SECOND_LEN > 1) ? $clog2(MAX_SECOND_LEN) : 1;
    localparam int NCOLS  = MAX_SECOND_LEN + 1;
    localparam int NCELLS = (MAX_FIRST_LEN + 1) * NCOLS;
    localparam int MW     = $clog2(NCELLS);
    localparam int STW    = $clog2(MAX_FIRST_LEN + MAX_SECOND_LEN + 1);
    localparam int EQW    = $clog2(MAX_FIRST_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FRD, S_FCALC, S_TRD1, S_TRD2, S_TCMP
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [7:0] match_reg, mismatch_reg, gopen_reg, gext_reg;
    logic       cfg_wr;

    // Sequence lengths and walk counters
    logic [IW-1:0] first_len_reg;
    logic [JW-1:0] second_len_reg;
    logic [IW-1:0] i_reg, si_reg, best_i_reg;
    logic [JW-1:0] j_reg, sj_reg, best_j_reg;

    // Fill datapath registers
    logic signed [SW-1:0] hdiag_reg, hleft_reg, ins_reg, best_reg;
    // Traceback captures
    logic signed [SW-1:0] th_reg, td_reg;
    logic                 teq_reg;
    logic [STW-1:0]       steps_reg;
    logic [EQW-1:0]       same_reg;

    // Result registers
    logic        done_reg, status_reg;
    logic [13:0] best_out_reg;
    logic [7:0]  fs_reg, fe_reg, ss_reg, se_reg, eqc_reg;
    logic [8:0]  pl_reg;

    // Memory ports
    logic           s1_we, s2_we, m_we;
    logic [A1W-1:0] s1_raddr;
    logic [A2W-1:0] s2_raddr;
    logic [7:0]     s1_rdata, s2_rdata;
    logic [MW-1:0]  m_raddr, m_waddr;
    logic [2*SW-1:0] m_wdata, m_rdata;
    logic [IW-1:0]  row_sel;
    logic [JW-1:0]  col_sel;

    // Cell arithmetic
    logic signed [SW-1:0] m_s, mm_s, go_s, ge_s, sub_s;
    logic signed [SW-1:0] hup, dup, diag_v, d_v, in_v, h_v, dd_a, dd_b, ii_a, ii_b;
    logic signed [SW-1:0] hd_t, diag_t;
    logic                 eq_f;
    logic                 accept;
    logic [31:0]          fs_w, fe_w, ss_w, se_w, pl_w, eq_w;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    assign m_s  = {{(SW-8){match_reg[7]}}, match_reg};
    assign mm_s = {{(SW-8){mismatch_reg[7]}}, mismatch_reg};
    assign go_s = {{(SW-8){gopen_reg[7]}}, gopen_reg};
    assign ge_s = {{(SW-8){gext_reg[7]}}, gext_reg};

    // Read back configuration
    always_comb
    begin
        case (paddr[3:2])
            ala_pkg::REG_MATCH:    prdata = {24'd0, match_reg};
            ala_pkg::REG_MISMATCH: prdata = {24'd0, mismatch_reg};
            ala_pkg::REG_GAP_OPEN: prdata = {24'd0, gopen_reg};
            ala_pkg::REG_GAP_EXT:  prdata = {24'd0, gext_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // Sequence stores
    assign s1_we = accept && (opcode == ala_pkg::OP_LOAD_FIRST)
                   && (first_len_reg < IW'(MAX_FIRST_LEN));
    assign s2_we = accept && (opcode == ala_pkg::OP_LOAD_SECOND)
                   && (second_len_reg < JW'(MAX_SECOND_LEN));

    always_comb
    begin
        if (state_reg == S_FRD)
        begin
            s1_raddr = A1W'(i_reg - IW'(1));
            s2_raddr = A2W'(j_reg - JW'(1));
        end
        else
        begin
            s1_raddr = A1W'(si_reg - IW'(1));
            s2_raddr = A2W'(sj_reg - JW'(1));
        end
    end

    ala_ram #(.WIDTH(8), .DEPTH(MAX_FIRST_LEN), .ADDR_W(A1W)) u_first (
        .clk(clk), .we(s1_we), .waddr(A1W'(first_len_reg)), .wdata(symbol),
        .raddr(s1_raddr), .rdata(s1_rdata)
    );

    ala_ram #(.WIDTH(8), .DEPTH(MAX_SECOND_LEN), .ADDR_W(A2W)) u_second (
        .clk(clk), .we(s2_we), .waddr(A2W'(second_len_reg)), .wdata(symbol),
        .raddr(s2_raddr), .rdata(s2_rdata)
    );

    // Pick the matrix cell to read: row above in fill, current or diagonal in traceback
    always_comb
    begin
        case (state_reg)
            S_FRD:
            begin
                row_sel = i_reg - IW'(1);
                col_sel = j_reg;
            end
            S_TRD1:
            begin
                row_sel = si_reg;
                col_sel = sj_reg;
            end
            default:
            begin
                row_sel = si_reg - IW'(1);
                col_sel = sj_reg - JW'(1);
            end
        endcase
    end

    assign m_raddr = MW'(MW'(row_sel) * MW'(NCOLS)) + MW'(col_sel);
    assign m_waddr = MW'(MW'(i_reg) * MW'(NCOLS)) + MW'(j_reg);
    assign m_we    = (state_reg == S_FCALC);
    assign m_wdata = {h_v, d_v};

    ala_ram #(.WIDTH(2*SW), .DEPTH(NCELLS), .ADDR_W(MW)) u_matrix (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    // Compute one cell from the row above, the left neighbor and the diagonal
    always_comb
    begin
        eq_f   = (s1_rdata == s2_rdata);
        sub_s  = eq_f ? m_s : mm_s;
        hup    = (i_reg == IW'(1)) ? '0 : m_rdata[2*SW-1:SW];
        dup    = (i_reg == IW'(1)) ? '0 : m_rdata[SW-1:0];
        diag_v = hdiag_reg + sub_s;
        dd_a   = hup + go_s;
        dd_b   = dup + ge_s;
        d_v    = (dd_a > dd_b) ? dd_a : dd_b;
        ii_a   = hleft_reg + go_s;
        ii_b   = ins_reg + ge_s;
        in_v   = (ii_a > ii_b) ? ii_a : ii_b;
        h_v    = (diag_v > d_v) ? diag_v : d_v;
        h_v    = (h_v > in_v) ? h_v : in_v;
        h_v    = (h_v > 0) ? h_v : '0;
        hd_t   = ((si_reg == IW'(1)) || (sj_reg == JW'(1))) ? '0 : m_rdata[2*SW-1:SW];
        diag_t = hd_t + (teq_reg ? m_s : mm_s);
    end

    // Widen counters for the fixed-width result fields
    assign fs_w = 32'(si_reg);
    assign fe_w = 32'(best_i_reg);
    assign ss_w = 32'(sj_reg);
    assign se_w = 32'(best_j_reg);
    assign pl_w = 32'(steps_reg);
    assign eq_w = 32'(same_reg);

    // Control, counters and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            match_reg      <= 8'sd1;
            mismatch_reg   <= 8'hFF;
            gopen_reg      <= 8'hFE;
            gext_reg       <= 8'hFF;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            si_reg         <= '0;
            sj_reg         <= '0;
            best_i_reg     <= '0;
            best_j_reg     <= '0;
            hdiag_reg      <= '0;
            hleft_reg      <= '0;
            ins_reg        <= '0;
            best_reg       <= '0;
            th_reg         <= '0;
            td_reg         <= '0;
            teq_reg        <= 1'b0;
            steps_reg      <= '0;
            same_reg       <= '0;
            done_reg       <= 1'b0;
            status_reg     <= 1'b0;
            best_out_reg   <= '0;
            fs_reg         <= '0;
            fe_reg         <= '0;
            ss_reg         <= '0;
            se_reg         <= '0;
            pl_reg         <= '0;
            eqc_reg        <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_wr)
            begin
                case (paddr[3:2])
                    ala_pkg::REG_MATCH:    match_reg    <= pwdata[7:0];
                    ala_pkg::REG_MISMATCH: mismatch_reg <= pwdata[7:0];
                    ala_pkg::REG_GAP_OPEN: gopen_reg    <= pwdata[7:0];
                    ala_pkg::REG_GAP_EXT:  gext_reg     <= pwdata[7:0];
                    default:               ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (ala_pkg::opcode_t'(opcode))
                            ala_pkg::OP_LOAD_FIRST:
                            begin
                                if (s1_we)
                                begin
                                    first_len_reg <= first_len_reg + IW'(1);
                                end
                            end
                            ala_pkg::OP_LOAD_SECOND:
                            begin
                                if (s2_we)
                                begin
                                    second_len_reg <= second_len_reg + JW'(1);
                                end
                            end
                            ala_pkg::OP_CLEAR:
                            begin
                                first_len_reg  <= '0;
                                second_len_reg <= '0;
                            end
                            ala_pkg::OP_ALIGN:
                            begin
                                if ((first_len_reg == '0) || (second_len_reg == '0))
                                begin
                                    done_reg     <= 1'b1;
                                    status_reg   <= ala_pkg::STATUS_EMPTY;
                                    best_out_reg <= '0;
                                    fs_reg       <= '0;
                                    fe_reg       <= '0;
                                    ss_reg       <= '0;
                                    se_reg       <= '0;
                                    pl_reg       <= '0;
                                    eqc_reg      <= '0;
                                end
                                else
                                begin
                                    i_reg      <= IW'(1);
                                    j_reg      <= JW'(1);
                                    hdiag_reg  <= '0;
                                    hleft_reg  <= '0;
                                    ins_reg    <= '0;
                                    best_reg   <= '0;
                                    best_i_reg <= '0;
                                    best_j_reg <= '0;
                                    steps_reg  <= '0;
                                    same_reg   <= '0;
                                    state_reg  <= S_FRD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FRD:
                begin
                    state_reg <= S_FCALC;
                end
                S_FCALC:
                begin
                    if (h_v > best_reg)
                    begin
                        best_reg   <= h_v;
                        best_i_reg <= i_reg;
                        best_j_reg <= j_reg;
                    end
                    if (JW'(second_len_reg) == j_reg)
                    begin
                        hdiag_reg <= '0;
                        hleft_reg <= '0;
                        ins_reg   <= '0;
                        j_reg     <= JW'(1);
                        if (i_reg == first_len_reg)
                        begin
                            // Trace back from the best cell (or the latest one found now)
                            si_reg    <= (h_v > best_reg) ? i_reg : best_i_reg;
                            sj_reg    <= (h_v > best_reg) ? j_reg : best_j_reg;
                            state_reg <= S_TRD1;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IW'(1);
                            state_reg <= S_FRD;
                        end
                    end
                    else
                    begin
                        hdiag_reg <= hup;
                        hleft_reg <= h_v;
                        ins_reg   <= in_v;
                        j_reg     <= j_reg + JW'(1);
                        state_reg <= S_FRD;
                    end
                end
                S_TRD1:
                begin
                    if ((si_reg == '0) || (sj_reg == '0))
                    begin
                        done_reg     <= 1'b1;
                        status_reg   <= ala_pkg::STATUS_DONE;
                        best_out_reg <= best_reg[13:0];
                        fs_reg       <= fs_w[7:0];
                        fe_reg       <= fe_w[7:0];
                        ss_reg       <= ss_w[7:0];
                        se_reg       <= se_w[7:0];
                        pl_reg       <= pl_w[8:0];
                        eqc_reg      <= eq_w[7:0];
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_TRD2;
                    end
                end
                S_TRD2:
                begin
                    th_reg  <= m_rdata[2*SW-1:SW];
                    td_reg  <= m_rdata[SW-1:0];
                    teq_reg <= eq_f;
                    if ($signed(m_rdata[2*SW-1:SW]) <= 0)
                    begin
                        done_reg     <= 1'b1;
                        status_reg   <= ala_pkg::STATUS_DONE;
                        best_out_reg <= best_reg[13:0];
                        fs_reg       <= fs_w[7:0];
                        fe_reg       <= fe_w[7:0];
                        ss_reg       <= ss_w[7:0];
                        se_reg       <= se_w[7:0];
                        pl_reg       <= pl_w[8:0];
                        eqc_reg      <= eq_w[7:0];
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_TCMP;
                    end
                end
                S_TCMP:
                begin
                    // Step diagonal, up or left
                    if (th_reg == diag_t)
                    begin
                        if (teq_reg)
                        begin
                            same_reg <= same_reg + EQW'(1);
                        end
                        si_reg <= si_reg - IW'(1);
                        sj_reg <= sj_reg - JW'(1);
                    end
                    else if (th_reg == td_reg)
                    begin
                        si_reg <= si_reg - IW'(1);
                    end
                    else
                    begin
                        sj_reg <= sj_reg - JW'(1);
                    end
                    steps_reg <= steps_reg + STW'(1);
                    state_reg <= S_TRD1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign best_score   = best_out_reg;
    assign first_start  = fs_reg;
    assign first_end    = fe_reg;
    assign second_start = ss_reg;
    assign second_end   = se_reg;
    assign path_length  = pl_reg;
    assign equal_count  = eqc_reg;

    // A result beat only follows the return to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result beat while walking the matrix");

    // Align on an empty sequence answers with the error status next cycle
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == ala_pkg::OP_ALIGN)
         && ((first_len_reg == '0) || (second_len_reg == '0)))
        |=> (done_reg && (status_reg == ala_pkg::STATUS_EMPTY)))
        else $error("empty align gave no error beat");

    // Each traceback compare counts exactly one step
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TCMP) |=> (steps_reg == $past(steps_reg) + STW'(1)))
        else $error("traceback step not counted");

    // The fill never writes a border row or column
    a_border: assert property (@(posedge clk) disable iff (!rst_n)
        m_we |-> ((i_reg != '0) && (j_reg != '0)))
        else $error("fill wrote a border cell");

endmodule
